>>> design/hbtn_pkg.sv
// ----------------------------------------------------------------------------
// hbtn_pkg: shared types and constants of the bounded heap top-N selector
// Holds default sizes, register indexes, the engine state type and the
// status and result records passed between the engine and the top level.
// ----------------------------------------------------------------------------
package hbtn_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int DEF_HEAP_DEPTH = 1024;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_TAG_BITS   = 16;

  // Fixed widths of the registers and the result fields.
  localparam int CAP_BITS     = 11;
  localparam int RES_KEY_BITS = 32;
  localparam int TOTAL_BITS   = 32;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 11'd1024;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DESCENDING = 2'd1;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_DN_CMP,
    ST_PLACE,
    ST_DONE
  } hbtn_state_t;

  // Status from the engine to the handshake logic.
  typedef struct packed {
    logic idle;
    logic done;
  } hbtn_sts_t;

  // One result item.
  typedef struct packed {
    logic                    replaced;
    logic [CAP_BITS-1:0]     kept_count;
    logic [RES_KEY_BITS-1:0] worst_key;
    logic [TOTAL_BITS-1:0]   replace_total;
  } hbtn_res_t;

endpackage

>>> design/bounded_heap_top_n_unit.sv
// ----------------------------------------------------------------------------
// bounded_heap_top_n_unit: top-N row selection with a bounded heap
// Configuration registers, input and result handshakes, result register,
// heap RAM and the heap update engine.
//
//   channel  signals                                   carries
//   -------  ----------------------------------------  -------------------------
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  register writes
//   row      row_valid, row_ready, sort_key, row_tag    one row item in
//   res      res_valid, res_ready, replaced, ...        one result item per row
//
// An inserted row makes c parent compares and is then placed, where c is
// none for the first row, k when it climbs k levels up to the root, and
// k + 1 when it climbs k levels and stops below the root. A replacement of
// the top makes k + 1 child compares for k levels of descent, since the last
// compare finds no swap, and is then placed; a rejected row goes straight to
// its result. k is at most log2(HEAP_DEPTH). Each level is one pass of the
// RAM read/compare/write loop, using two read ports for the two children.
// The result register lets the next row start while a result waits; the
// engine holds its finished item only when that register is full.
// Reset clears counters and control; the heap RAM needs no clearing pass.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module bounded_heap_top_n_unit
  import hbtn_pkg::*;
#(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int TAG_BITS   = DEF_TAG_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CAP_BITS-1:0]     cfg_data,
  input  logic                    row_valid,
  output logic                    row_ready,
  input  logic [KEY_BITS-1:0]     sort_key,
  input  logic [TAG_BITS-1:0]     row_tag,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic                    replaced,
  output logic [CAP_BITS-1:0]     kept_count,
  output logic [RES_KEY_BITS-1:0] worst_key,
  output logic [TOTAL_BITS-1:0]   replace_total
);

  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int IW = KEY_BITS + TAG_BITS;

  logic [CAP_BITS-1:0] capacity;
  logic                descending;
  hbtn_sts_t           sts;
  hbtn_res_t           eng_res;
  hbtn_res_t           res_q;
  logic                slot_free;
  logic                start;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [IW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_ra;
  logic [AW-1:0]       ram_rb;
  logic [IW-1:0]       ram_qa;
  logic [IW-1:0]       ram_qb;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAP_RESET;
      descending <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CAPACITY:   capacity   <= cfg_data;
        REG_DESCENDING: descending <= cfg_data[0];
        default: begin
          capacity <= capacity;
        end
      endcase
    end
  end

  // Row handshake: a new item starts only when the engine is idle.
  assign row_ready = sts.idle;
  assign start     = row_valid && row_ready;

  // Result register, loaded when the engine finishes and the slot is free.
  assign slot_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (sts.done && slot_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done && slot_free) begin
      res_q <= eng_res;
    end
  end

  assign replaced      = res_q.replaced;
  assign kept_count    = res_q.kept_count;
  assign worst_key     = res_q.worst_key;
  assign replace_total = res_q.replace_total;

  // Heap storage: key and tag side by side in one entry.
  hbtn_ram #(
    .WIDTH (IW),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .ra_addr (ram_ra),
    .ra_data (ram_qa),
    .rb_addr (ram_rb),
    .rb_data (ram_qb)
  );

  hbtn_engine #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_BITS   (KEY_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_key  (sort_key),
    .start_tag  (row_tag),
    .capacity   (capacity),
    .descending (descending),
    .slot_free  (slot_free),
    .sts        (sts),
    .res        (eng_res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_ra     (ram_ra),
    .ram_rb     (ram_rb),
    .ram_qa     (ram_qa),
    .ram_qb     (ram_qb)
  );

endmodule

>>> design/hbtn_ram.sv
// ----------------------------------------------------------------------------
// hbtn_ram: generic synchronous RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hbtn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and both registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

>>> design/hbtn_engine.sv
// ----------------------------------------------------------------------------
// hbtn_engine: heap update sequencer
// Inserts a row with a sift-up or replaces the heap top with a sift-down,
// one tree level per cycle, reading and writing the heap RAM. Keeps the fill
// count, the replacement counter and a copy of the heap top key.
// ----------------------------------------------------------------------------
module hbtn_engine
  import hbtn_pkg::*;
#(
  parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
  parameter int KEY_BITS   = DEF_KEY_BITS,
  parameter int TAG_BITS   = DEF_TAG_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [KEY_BITS-1:0]           start_key,
  input  logic [TAG_BITS-1:0]           start_tag,
  input  logic [CAP_BITS-1:0]           capacity,
  input  logic                          descending,
  input  logic                          slot_free,
  output hbtn_sts_t                     sts,
  output hbtn_res_t                     res,
  output logic                          ram_we,
  output logic [$clog2(HEAP_DEPTH)-1:0] ram_waddr,
  output logic [KEY_BITS+TAG_BITS-1:0]  ram_wdata,
  output logic [$clog2(HEAP_DEPTH)-1:0] ram_ra,
  output logic [$clog2(HEAP_DEPTH)-1:0] ram_rb,
  input  logic [KEY_BITS+TAG_BITS-1:0]  ram_qa,
  input  logic [KEY_BITS+TAG_BITS-1:0]  ram_qb
);

  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam int LW    = AW + 2;
  localparam int IW    = KEY_BITS + TAG_BITS;

  // True when key a ranks worse than key b, so it belongs nearer the top.
  function automatic logic worse(input logic [KEY_BITS-1:0] a,
                                 input logic [KEY_BITS-1:0] b,
                                 input logic                desc);
    worse = desc ? (a < b) : (a > b);
  endfunction

  hbtn_state_t state, state_next;

  logic [CNT_W-1:0]      fill_count;
  logic [TOTAL_BITS-1:0] replace_count;
  logic                  replaced_flag;
  logic [KEY_BITS-1:0]   hold_key;
  logic [TAG_BITS-1:0]   hold_tag;
  logic [AW-1:0]         idx;
  logic [AW-1:0]         par;
  logic [KEY_BITS-1:0]   top_key;

  logic [CMP_W-1:0]    cap_eff;
  logic                has_room;
  logic                beats_top;
  logic [AW-1:0]       slot;
  logic [AW-1:0]       slot_par;
  logic [AW-1:0]       par_up;
  logic [KEY_BITS-1:0] qa_key;
  logic [KEY_BITS-1:0] qb_key;
  logic                up_swap;
  logic [LW-1:0]       l_w;
  logic [LW-1:0]       r_w;
  logic                l_ok;
  logic                r_ok;
  logic                pick_r;
  logic [AW-1:0]       c_idx;
  logic [IW-1:0]       c_item;
  logic                dn_swap;
  logic [LW-1:0]       cl_w;
  logic [LW-1:0]       cr_w;

  // Capacity clamped to the range 1 .. HEAP_DEPTH.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(HEAP_DEPTH)) begin
      cap_eff = CMP_W'(HEAP_DEPTH);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign has_room  = CMP_W'(fill_count) < cap_eff;
  assign beats_top = worse(top_key, start_key, descending);

  // Index arithmetic for sift-up.
  assign slot     = fill_count[AW-1:0];
  assign slot_par = (slot - AW'(1)) >> 1;
  assign par_up   = (par - AW'(1)) >> 1;

  // Read data split into key and tag.
  assign qa_key  = ram_qa[IW-1:TAG_BITS];
  assign qb_key  = ram_qb[IW-1:TAG_BITS];
  assign up_swap = worse(hold_key, qa_key, descending);

  // Children of the current node and the choice between them for sift-down.
  assign l_w     = LW'({idx, 1'b1});
  assign r_w     = l_w + LW'(1);
  assign l_ok    = l_w < LW'(fill_count);
  assign r_ok    = r_w < LW'(fill_count);
  assign pick_r  = r_ok && worse(qb_key, qa_key, descending);
  assign c_idx   = pick_r ? r_w[AW-1:0] : l_w[AW-1:0];
  assign c_item  = pick_r ? ram_qb : ram_qa;
  assign dn_swap = l_ok && worse(c_item[IW-1:TAG_BITS], hold_key, descending);
  assign cl_w    = LW'({c_idx, 1'b1});
  assign cr_w    = cl_w + LW'(1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (has_room) begin
            state_next = (slot == '0) ? ST_PLACE : ST_UP_CMP;
          end else if (beats_top) begin
            state_next = ST_DN_CMP;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_UP_CMP: begin
        state_next = (up_swap && (par != '0)) ? ST_UP_CMP : ST_PLACE;
      end
      ST_DN_CMP: begin
        state_next = dn_swap ? ST_DN_CMP : ST_PLACE;
      end
      ST_PLACE: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // RAM port control and status.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = {hold_key, hold_tag};
    ram_ra    = '0;
    ram_rb    = '0;
    sts.idle  = 1'b0;
    sts.done  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        sts.idle = 1'b1;
        ram_ra   = has_room ? slot_par : AW'(1);
        ram_rb   = AW'(2);
      end
      ST_UP_CMP: begin
        ram_we    = up_swap;
        ram_wdata = ram_qa;
        ram_ra    = par_up;
      end
      ST_DN_CMP: begin
        ram_we    = dn_swap;
        ram_wdata = c_item;
        ram_ra    = cl_w[AW-1:0];
        ram_rb    = cr_w[AW-1:0];
      end
      ST_PLACE: begin
        ram_we = 1'b1;
      end
      ST_DONE: begin
        sts.done = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control state: sequencer, fill count and replacement counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fill_count    <= '0;
      replace_count <= '0;
      replaced_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && start) begin
        replaced_flag <= 1'b0;
        if (has_room) begin
          fill_count <= fill_count + CNT_W'(1);
        end else if (beats_top) begin
          replaced_flag <= 1'b1;
          if (replace_count != '1) begin
            replace_count <= replace_count + TOTAL_BITS'(1);
          end
        end
      end
    end
  end

  // Item being placed and the walk position.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          hold_key <= start_key;
          hold_tag <= start_tag;
          idx      <= has_room ? slot : '0;
          par      <= slot_par;
        end
      end
      ST_UP_CMP: begin
        if (up_swap) begin
          idx <= par;
          par <= par_up;
        end
      end
      ST_DN_CMP: begin
        if (dn_swap) begin
          idx <= c_idx;
        end
      end
      default: begin
        idx <= idx;
      end
    endcase
  end

  // Copy of the heap top, taken from every write to the root entry.
  always_ff @(posedge clk) begin
    if (ram_we && ram_waddr == '0) begin
      top_key <= ram_wdata[IW-1:TAG_BITS];
    end
  end

  // Result fields of the finished item.
  always_comb begin
    res.replaced      = replaced_flag;
    res.kept_count    = CAP_BITS'(fill_count);
    res.worst_key     = (fill_count != '0) ? RES_KEY_BITS'(top_key) : '0;
    res.replace_total = replace_count;
  end

  // Writes only land on occupied entries.
  a_write_in_fill: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CNT_W'(ram_waddr) < fill_count))
    else $error("heap write beyond the fill count");

  // The fill count never passes the heap depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(HEAP_DEPTH))
    else $error("fill count above heap depth");

  // A sift-down step never changes the fill count.
  a_dn_fill_stable: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DN_CMP) |=> $stable(fill_count))
    else $error("fill count changed during sift-down");

  // The replacement counter never goes backward.
  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !rst |=> (replace_count >= $past(replace_count)))
    else $error("replacement counter decreased");

endmodule

>>> bench/bounded_heap_top_n_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_heap_top_n_checker: result checker for the top-N selector
// Watches the register, row and result channels of the selector. It keeps its
// own copy of the bounded heap, predicts one result item for every accepted
// row, and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_heap_top_n_checker
  import hbtn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CAP_BITS-1:0]     cfg_data,
  input  logic                    row_valid,
  input  logic                    row_ready,
  input  logic [DEF_KEY_BITS-1:0] sort_key,
  input  logic [DEF_TAG_BITS-1:0] row_tag,
  input  logic                    res_valid,
  input  logic                    res_ready,
  input  logic                    replaced,
  input  logic [CAP_BITS-1:0]     kept_count,
  input  logic [RES_KEY_BITS-1:0] worst_key,
  input  logic [TOTAL_BITS-1:0]   replace_total,
  output int                      mismatches,
  output int                      outstanding
);

  // One kept row of the predicted heap.
  typedef struct packed {
    logic [DEF_KEY_BITS-1:0] key;
    logic [DEF_TAG_BITS-1:0] tag;
  } heap_row_t;

  heap_row_t             heap_mem [DEF_HEAP_DEPTH];
  int unsigned           rows_kept;
  logic [TOTAL_BITS-1:0] evictions;
  logic [CAP_BITS-1:0]   capacity_reg;
  logic                  descending_reg;
  hbtn_res_t             pending_results [$];

  initial outstanding = 0;

  // True when key a belongs nearer the heap top than key b.
  function automatic bit ranks_worse(logic [DEF_KEY_BITS-1:0] a, logic [DEF_KEY_BITS-1:0] b);
    return descending_reg ? (a < b) : (a > b);
  endfunction

  // Move a freshly appended row up while it ranks strictly worse than its parent.
  function automatic void climb(int unsigned slot);
    int unsigned parent;
    heap_row_t   tmp;
    while (slot > 0) begin
      parent = (slot - 1) / 2;
      if (!ranks_worse(heap_mem[slot].key, heap_mem[parent].key)) break;
      tmp              = heap_mem[slot];
      heap_mem[slot]   = heap_mem[parent];
      heap_mem[parent] = tmp;
      slot             = parent;
    end
  endfunction

  // Move a new top row down toward the worse of its children.
  function automatic void sink(int unsigned n);
    int unsigned node;
    int unsigned left;
    int unsigned right;
    int unsigned pick;
    heap_row_t   tmp;
    node = 0;
    while (1) begin
      left  = 2 * node + 1;
      right = left + 1;
      if (left >= n) break;
      pick = left;
      if (right < n && ranks_worse(heap_mem[right].key, heap_mem[left].key)) pick = right;
      if (!ranks_worse(heap_mem[pick].key, heap_mem[node].key)) break;
      tmp            = heap_mem[node];
      heap_mem[node] = heap_mem[pick];
      heap_mem[pick] = tmp;
      node           = pick;
    end
  endfunction

  // Apply one row to the predicted heap and return the result it should give.
  function automatic hbtn_res_t predict_row(logic [DEF_KEY_BITS-1:0] new_key,
                                            logic [DEF_TAG_BITS-1:0] new_tag);
    hbtn_res_t   res;
    int unsigned limit;
    // A capacity of zero behaves as one, and one above the depth as the depth.
    limit = capacity_reg;
    if (limit < 1) limit = 1;
    if (limit > DEF_HEAP_DEPTH) limit = DEF_HEAP_DEPTH;
    res.replaced = 1'b0;
    if (rows_kept < limit) begin
      heap_mem[rows_kept].key = new_key;
      heap_mem[rows_kept].tag = new_tag;
      rows_kept++;
      climb(rows_kept - 1);
    end else if (ranks_worse(heap_mem[0].key, new_key)) begin
      // Only a strictly better key evicts the worst kept row.
      heap_mem[0].key = new_key;
      heap_mem[0].tag = new_tag;
      sink(rows_kept);
      res.replaced = 1'b1;
      if (evictions != '1) evictions++;
    end
    res.kept_count    = CAP_BITS'(rows_kept);
    res.worst_key     = (rows_kept > 0) ? heap_mem[0].key : '0;
    res.replace_total = evictions;
    return res;
  endfunction

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Track register writes, check result items, then predict new row items.
  always @(posedge clk) begin
    hbtn_res_t want;
    if (rst) begin
      rows_kept      = 0;
      evictions      = '0;
      capacity_reg   = CAP_RESET;
      descending_reg = 1'b0;
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAPACITY:   capacity_reg = cfg_data;
          REG_DESCENDING: descending_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result item with no row waiting (kept_count %0d)",
                                    kept_count));
        end else begin
          want = pending_results.pop_front();
          if (replaced !== want.replaced)
            report_mismatch($sformatf("replaced got %b expected %b",
                                      replaced, want.replaced));
          if (kept_count !== want.kept_count)
            report_mismatch($sformatf("kept_count got %0d expected %0d",
                                      kept_count, want.kept_count));
          if (worst_key !== want.worst_key)
            report_mismatch($sformatf("worst_key got %h expected %h",
                                      worst_key, want.worst_key));
          if (replace_total !== want.replace_total)
            report_mismatch($sformatf("replace_total got %0d expected %0d",
                                      replace_total, want.replace_total));
        end
      end
      if (row_valid && row_ready) pending_results.push_back(predict_row(sort_key, row_tag));
    end
    outstanding <= pending_results.size();
  end

endmodule

>>> bench/bounded_heap_top_n_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_heap_top_n_unit_test: testbench of the bounded heap top-N selector
// Drives register settings and row items with random bursts and gaps, stalls
// the result channel at random, and leaves prediction and comparison to the
// checker placed beside the selector. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module bounded_heap_top_n_unit_test;
  import hbtn_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_CAPACITY;
  logic [CAP_BITS-1:0]     cfg_data = '0;
  logic                    row_valid = 1'b0;
  logic                    row_ready;
  logic [DEF_KEY_BITS-1:0] sort_key = '0;
  logic [DEF_TAG_BITS-1:0] row_tag = '0;
  logic                    res_valid;
  logic                    res_ready = 1'b0;
  logic                    replaced;
  logic [CAP_BITS-1:0]     kept_count;
  logic [RES_KEY_BITS-1:0] worst_key;
  logic [TOTAL_BITS-1:0]   replace_total;
  int                      mismatches;
  int                      outstanding;
  int                      burst_left = 0;
  int                      hold_left = 0;
  int                      quiet_cycles = 0;

  bounded_heap_top_n_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .row_valid     (row_valid),
    .row_ready     (row_ready),
    .sort_key      (sort_key),
    .row_tag       (row_tag),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .replaced      (replaced),
    .kept_count    (kept_count),
    .worst_key     (worst_key),
    .replace_total (replace_total)
  );

  bounded_heap_top_n_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .row_valid     (row_valid),
    .row_ready     (row_ready),
    .sort_key      (sort_key),
    .row_tag       (row_tag),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .replaced      (replaced),
    .kept_count    (kept_count),
    .worst_key     (worst_key),
    .replace_total (replace_total),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side alternates between stalls, short ready runs and long ready runs.
  always @(negedge clk) begin
    if (hold_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        res_ready <= 1'b0;
        hold_left <= $urandom_range(1, 20);
      end else begin
        res_ready <= 1'b1;
        hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 8);
      end
    end else begin
      hold_left <= hold_left - 1;
    end
  end

  // End the run when no item moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (row_valid && row_ready) ||
        (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Keys mix full range values, small values full of ties, and the extremes.
  function automatic logic [DEF_KEY_BITS-1:0] pick_key();
    logic [DEF_KEY_BITS-1:0] k;
    case ($urandom_range(0, 7))
      0: k = $urandom_range(0, 15);
      1: k = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      2: begin
        case ($urandom_range(0, 3))
          0: k = '0;
          1: k = 32'd1;
          2: k = 32'hFFFF_FFFE;
          default: k = '1;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Offer one row item, opening a new burst after a random gap when one runs out.
  task automatic push_row(input logic [DEF_KEY_BITS-1:0] key,
                          input logic [DEF_TAG_BITS-1:0] tag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        row_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    row_valid <= 1'b1;
    sort_key  <= key;
    row_tag   <= tag;
    @(posedge clk);
    while (row_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Stop offering rows and wait until every predicted result has arrived.
  task automatic drain_rows();
    row_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write both registers while the selector is idle.
  task automatic reconfigure(input logic [CAP_BITS-1:0] capacity, input logic descending);
    drain_rows();
    cfg_valid <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= capacity;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_index <= REG_DESCENDING;
    cfg_data  <= CAP_BITS'(descending);
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random phase under a single register setting.
  task automatic run_phase(input logic [CAP_BITS-1:0] capacity, input logic descending,
                           input int count);
    reconfigure(capacity, descending);
    repeat (count) push_row(pick_key(), DEF_TAG_BITS'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Capacity zero acts as one; ties and worse keys are rejected.
    reconfigure(11'd0, 1'b0);
    push_row(32'd5, 16'h0000);
    push_row(32'd5, 16'hFFFF);
    push_row(32'd9, 16'h0001);
    push_row(32'd2, 16'h0002);
    push_row(32'd0, 16'h0003);
    push_row(32'd0, 16'h0004);
    push_row(32'hFFFF_FFFF, 16'h0005);

    // Descending with one row kept: only a larger key replaces it.
    reconfigure(11'd1, 1'b1);
    push_row(32'd0, 16'h0006);
    push_row(32'hFFFF_FFFF, 16'hFFFF);
    push_row(32'd7, 16'h0007);

    // Grow to four rows in descending mode, then replace the smallest.
    reconfigure(11'd4, 1'b1);
    push_row(32'd100, 16'h0008);
    push_row(32'hFFFF_FFFE, 16'h0009);
    push_row(32'd3, 16'h000A);
    push_row(32'd50, 16'h000B);
    push_row(32'hFFFF_FFFF, 16'h000C);

    // Flip to ascending without rebuilding the stored order.
    reconfigure(11'd4, 1'b0);
    push_row(32'd1, 16'h000D);
    push_row(32'hFFFF_FFFF, 16'h000E);
    push_row(32'd60, 16'h000F);
    push_row(32'd0, 16'h0000);

    // Random phases; capacity two lies below the fill, 2047 acts as the depth.
    run_phase(11'd16, 1'b0, 50);
    run_phase(11'd2, 1'b1, 30);
    run_phase(11'd64, 1'b0, 70);
    run_phase(11'd1024, 1'b1, 800);
    run_phase(11'd2047, 1'b0, 200);

    drain_rows();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
